// ===== design/hck_pkg.sv =====
// Shared types and constants for the 2x2 Hill key recovery pipeline.
// No dependencies; imported by every module of the block.
package hck_pkg;

    localparam int IN_W  = 5;
    localparam int KEY_W = 5;
    localparam int N_ENT = 4;
    localparam int NSTG  = 12;

    localparam int ST_RED   = 0;
    localparam int ST_DPROD = 1;
    localparam int ST_DSUM  = 2;
    localparam int ST_DQ    = 3;
    localparam int ST_DET   = 4;
    localparam int ST_INV   = 5;
    localparam int ST_IPROD = 6;
    localparam int ST_IQ    = 7;
    localparam int ST_PINV  = 8;
    localparam int ST_KSUM  = 9;
    localparam int ST_KQ    = 10;
    localparam int ST_KEY   = 11;

    typedef struct packed {
        logic [NSTG-1:0] en;
        logic [NSTG-1:0] vld;
    } t_pipe_ctl;

    typedef struct packed {
        logic en_q;
        logic en_r;
    } t_red_en;

endpackage

// ===== design/hill_cipher_key_recovery_2x2_core.sv =====
// Hill cipher 2x2 known-plaintext key recovery: K = C * P^-1 mod alphabet size.
// Depends on hck_pkg, hck_pipe_ctl and hck_modred.
//
// One request (P and C) is accepted per clock unless a stalled output has filled
// every stage. The pipeline depth comes from three modular reductions
// (determinant, inverse matrix, key product), each a reciprocal multiply stage
// followed by a multiply-subtract stage, with product and table stages between
// them. Each stage has its own valid bit, so a stalled output only holds the
// stages that are actually full. When the plaintext determinant has no inverse
// the singular flag is set in tuser and the key fields are zero.
module hill_cipher_key_recovery_2x2_core import hck_pkg::*; #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // plain_r0c0, plain_r0c1, plain_r1c0, plain_r1c1,
    // cipher_r0c0, cipher_r0c1, cipher_r1c0, cipher_r1c1 (5 bits each)
    input  logic [39:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // key_r0c0, key_r0c1, key_r1c0, key_r1c1 (5 bits each), 4 zero bits
    output logic [23:0] o_m_tdata,
    // singular
    output logic [0:0]  o_m_tuser
);

    localparam int W    = $clog2(ALPHABET_SIZE);
    localparam int XW   = 2 * W + 1;
    localparam int PW   = 2 * W;
    localparam int TBL  = 2 ** W;
    localparam int NRED = 2 ** IN_W;
    localparam logic [XW-1:0] MM = XW'(ALPHABET_SIZE * ALPHABET_SIZE);

    function automatic int inv_of(int d);
        int r;
        r = 0;
        for (int x = ALPHABET_SIZE - 1; x >= 1; x--) begin
            if (((d * x) % ALPHABET_SIZE) == 1) r = x;
        end
        return r;
    endfunction

    logic [W-1:0]   red_tbl [NRED];
    logic [W-1:0]   inv_tbl [TBL];
    logic [TBL-1:0] sing_tbl;

    for (genvar g = 0; g < NRED; g++) begin : g_red
        assign red_tbl[g] = W'(g % ALPHABET_SIZE);
    end

    for (genvar g = 0; g < TBL; g++) begin : g_inv
        assign inv_tbl[g]  = W'(inv_of(g));
        assign sing_tbl[g] = (inv_of(g) == 0);
    end

    t_pipe_ctl       w_ctl;
    logic [NSTG-1:0] en;

    hck_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_out_ready (i_m_tready),
        .o_in_ready  (o_s_tready),
        .o_ctl       (w_ctl)
    );

    assign en = w_ctl.en;

    // entry order in p/c vectors: r0c0, r0c1, r1c0, r1c1
    logic [N_ENT-1:0][W-1:0] r0_p, r0_c, r1_p, r1_c, r2_p, r2_c;
    logic [N_ENT-1:0][W-1:0] r3_p, r3_c, r4_p, r4_c;
    logic [PW-1:0]           r1_a, r1_b;
    logic [XW-1:0]           r2_x;

    always_ff @(posedge i_clk) begin
        if (en[ST_RED]) begin
            for (int l = 0; l < N_ENT; l++) begin
                r0_p[l] <= red_tbl[i_s_tdata[l*IN_W +: IN_W]];
                r0_c[l] <= red_tbl[i_s_tdata[(l+N_ENT)*IN_W +: IN_W]];
            end
        end
        if (en[ST_DPROD]) begin
            r1_a <= PW'(r0_p[0]) * PW'(r0_p[3]);
            r1_b <= PW'(r0_p[1]) * PW'(r0_p[2]);
            r1_p <= r0_p;
            r1_c <= r0_c;
        end
        if (en[ST_DSUM]) begin
            r2_x <= XW'(r1_a) + MM - XW'(r1_b);
            r2_p <= r1_p;
            r2_c <= r1_c;
        end
        if (en[ST_DQ]) begin
            r3_p <= r2_p;
            r3_c <= r2_c;
        end
        if (en[ST_DET]) begin
            r4_p <= r3_p;
            r4_c <= r3_c;
        end
    end

    logic [0:0][W-1:0] w_det;

    hck_modred #(.ALPHABET_SIZE(ALPHABET_SIZE), .LANES(1)) u_red_det (
        .i_clk (i_clk),
        .i_en  (t_red_en'{en_q: en[ST_DQ], en_r: en[ST_DET]}),
        .i_x   (r2_x),
        .o_r   (w_det)
    );

    // adjugate entries in pinv order: p11, -p01, -p10, p00
    logic [N_ENT-1:0][W-1:0]  r5_m, r5_c, r6_c, r7_c, r8_c;
    logic [W-1:0]             r5_dinv;
    logic                     r5_sing, r6_sing, r7_sing, r8_sing;
    logic                     r9_sing, r10_sing, r11_sing;
    logic [N_ENT-1:0][PW-1:0] r6_pr;
    logic [N_ENT-1:0][XW-1:0] w_ipx;
    logic [N_ENT-1:0][W-1:0]  w_pinv;
    logic [N_ENT-1:0][XW-1:0] r9_s;
    logic [N_ENT-1:0][W-1:0]  w_key;
    logic [W-1:0]             w_n01, w_n10;

    assign w_n01 = (r4_p[1] == '0) ? '0
                 : W'((W + 1)'(ALPHABET_SIZE) - (W + 1)'(r4_p[1]));
    assign w_n10 = (r4_p[2] == '0) ? '0
                 : W'((W + 1)'(ALPHABET_SIZE) - (W + 1)'(r4_p[2]));

    always_ff @(posedge i_clk) begin
        if (en[ST_INV]) begin
            r5_dinv <= inv_tbl[w_det[0]];
            r5_sing <= sing_tbl[w_det[0]];
            r5_m    <= {r4_p[0], w_n10, w_n01, r4_p[3]};
            r5_c    <= r4_c;
        end
        if (en[ST_IPROD]) begin
            for (int l = 0; l < N_ENT; l++) begin
                r6_pr[l] <= PW'(r5_m[l]) * PW'(r5_dinv);
            end
            r6_c    <= r5_c;
            r6_sing <= r5_sing;
        end
        if (en[ST_IQ]) begin
            r7_c    <= r6_c;
            r7_sing <= r6_sing;
        end
        if (en[ST_PINV]) begin
            r8_c    <= r7_c;
            r8_sing <= r7_sing;
        end
        if (en[ST_KSUM]) begin
            for (int i = 0; i < 2; i++) begin
                for (int j = 0; j < 2; j++) begin
                    r9_s[i*2+j] <= XW'(PW'(r8_c[i*2]) * PW'(w_pinv[j]))
                                 + XW'(PW'(r8_c[i*2+1]) * PW'(w_pinv[2+j]));
                end
            end
            r9_sing <= r8_sing;
        end
        if (en[ST_KQ]) begin
            r10_sing <= r9_sing;
        end
        if (en[ST_KEY]) begin
            r11_sing <= r10_sing;
        end
    end

    always_comb begin
        for (int l = 0; l < N_ENT; l++) begin
            w_ipx[l] = XW'(r6_pr[l]);
        end
    end

    hck_modred #(.ALPHABET_SIZE(ALPHABET_SIZE), .LANES(N_ENT)) u_red_pinv (
        .i_clk (i_clk),
        .i_en  (t_red_en'{en_q: en[ST_IQ], en_r: en[ST_PINV]}),
        .i_x   (w_ipx),
        .o_r   (w_pinv)
    );

    hck_modred #(.ALPHABET_SIZE(ALPHABET_SIZE), .LANES(N_ENT)) u_red_key (
        .i_clk (i_clk),
        .i_en  (t_red_en'{en_q: en[ST_KQ], en_r: en[ST_KEY]}),
        .i_x   (r9_s),
        .o_r   (w_key)
    );

    always_comb begin
        o_m_tdata = '0;
        for (int l = 0; l < N_ENT; l++) begin
            o_m_tdata[l*KEY_W +: KEY_W] = r11_sing ? '0 : KEY_W'(w_key[l]);
        end
    end

    assign o_m_tvalid   = w_ctl.vld[ST_KEY];
    assign o_m_tuser[0] = r11_sing;

endmodule

// ===== design/hck_pipe_ctl.sv =====
// Valid bits and per-stage load enables for the key recovery pipeline.
// Depends on hck_pkg.
module hck_pipe_ctl import hck_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    output logic      o_in_ready,
    output t_pipe_ctl o_ctl
);

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;
    logic [NSTG-1:0] w_en;

    // a stage loads when it is empty or the stage after it moves
    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        for (int k = 0; k < NSTG; k++) begin
            if (w_en[k]) begin
                n_vld[k] = (k == 0) ? i_in_valid : r_vld[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready = w_en[0];
    assign o_ctl.en   = w_en;
    assign o_ctl.vld  = r_vld;

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted request did not enter the first stage");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_out_ready) |-> !o_in_ready)
        else $error("full pipeline accepted a request");

    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ($countones(r_vld) == $countones($past(r_vld))
            + int'($past(i_in_valid && o_in_ready))
            - int'($past(r_vld[NSTG-1] && i_out_ready))))
        else $error("request lost or duplicated in pipeline");

endmodule

// ===== design/hck_modred.sv =====
// Two-stage reduction modulo the alphabet size: reciprocal multiply, then
// multiply-subtract with one correction. Depends on hck_pkg.
module hck_modred import hck_pkg::*; #(
    parameter  int ALPHABET_SIZE = 26,
    parameter  int LANES         = 1,
    localparam int W             = $clog2(ALPHABET_SIZE),
    localparam int XW            = 2 * W + 1
) (
    input  logic                       i_clk,
    input  t_red_en                    i_en,
    input  logic [LANES-1:0][XW-1:0]   i_x,
    output logic [LANES-1:0][W-1:0]    o_r
);

    localparam logic [XW-1:0] RECIP = XW'((64'(1) << XW) / ALPHABET_SIZE);

    logic [LANES-1:0][XW-1:0] r_x;
    logic [LANES-1:0][XW-1:0] r_q;
    logic [LANES-1:0][XW-1:0] w_prod_q;
    logic [LANES-1:0][W:0]    w_rem;
    logic [LANES-1:0][W-1:0]  w_fix;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_prod_q[l] = XW'(((2 * XW)'(i_x[l]) * (2 * XW)'(RECIP)) >> XW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_q) begin
            r_x <= i_x;
            r_q <= w_prod_q;
        end
    end

    // quotient estimate is low by at most one
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_rem[l] = (W + 1)'(r_x[l] - XW'(r_q[l] * XW'(ALPHABET_SIZE)));
            if (w_rem[l] >= (W + 1)'(ALPHABET_SIZE)) begin
                w_fix[l] = W'(w_rem[l] - (W + 1)'(ALPHABET_SIZE));
            end else begin
                w_fix[l] = W'(w_rem[l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_r) begin
            o_r <= w_fix;
        end
    end

endmodule

// ===== tb/hck_key_checker.sv =====
// Checker for hill_cipher_key_recovery_2x2_core: watches both stream channels,
// predicts the key for each accepted request and compares the results in order.
// Depends on hck_pkg for the field widths.
`timescale 1ns / 100ps

module hck_key_checker import hck_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    input  logic [0:0]  i_m_tuser,
    output int          o_fail_cnt,
    output int          o_pending
);

    localparam int ALPHA = 26;

    typedef struct packed {
        logic                            singular;
        logic [N_ENT-1:0][KEY_W-1:0]     key;
    } t_key_res;

    t_key_res key_expect_q[$];
    t_key_res want;
    t_key_res got;
    int       fails = 0;

    // K = C * inv(P) mod ALPHA, all zero with the singular flag when det(P) has no inverse
    function automatic t_key_res recover_key(input logic [39:0] d);
        int       p[4];
        int       c[4];
        int       pinv[4];
        int       det;
        int       dinv;
        int       s;
        t_key_res r;
        for (int i = 0; i < 4; i++) begin
            p[i] = int'(d[i*IN_W +: IN_W]) % ALPHA;
            c[i] = int'(d[(i+4)*IN_W +: IN_W]) % ALPHA;
        end
        det  = ((p[0] * p[3] - p[1] * p[2]) % ALPHA + ALPHA) % ALPHA;
        dinv = 0;
        for (int x = 1; x < ALPHA; x++) begin
            if (dinv == 0 && (det * x) % ALPHA == 1)
                dinv = x;
        end
        r = '0;
        if (dinv == 0) begin
            r.singular = 1'b1;
            return r;
        end
        pinv[0] = (p[3] * dinv) % ALPHA;
        pinv[1] = (((ALPHA - p[1]) % ALPHA) * dinv) % ALPHA;
        pinv[2] = (((ALPHA - p[2]) % ALPHA) * dinv) % ALPHA;
        pinv[3] = (p[0] * dinv) % ALPHA;
        for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
                s = (c[i*2] * pinv[j] + c[i*2+1] * pinv[2+j]) % ALPHA;
                r.key[i*2+j] = KEY_W'(s);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_expect_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                key_expect_q.push_back(recover_key(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got.key      = i_m_tdata[N_ENT*KEY_W-1:0];
                got.singular = i_m_tuser[0];
                if (key_expect_q.size() == 0) begin
                    $display("%0t: key result expected none actual key=%h singular=%b",
                             $time, got.key, got.singular);
                    fails++;
                end else begin
                    want = key_expect_q.pop_front();
                    for (int k = 0; k < N_ENT; k++) begin
                        if (got.key[k] !== want.key[k]) begin
                            $display("%0t: key entry %0d expected %0d actual %0d",
                                     $time, k, want.key[k], got.key[k]);
                            fails++;
                        end
                    end
                    if (got.singular !== want.singular) begin
                        $display("%0t: singular expected %b actual %b",
                                 $time, want.singular, got.singular);
                        fails++;
                    end
                    if (i_m_tdata[23:N_ENT*KEY_W] !== '0) begin
                        $display("%0t: tdata pad expected 0 actual %h",
                                 $time, i_m_tdata[23:N_ENT*KEY_W]);
                        fails++;
                    end
                end
            end
        end
        o_pending  <= key_expect_q.size();
        o_fail_cnt <= fails;
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the hill_cipher_key_recovery_2x2_core regression: clock, reset, request
// stimulus and output back-pressure; checking is done by hck_key_checker.
// Depends on hck_pkg, the core and tb/hck_key_checker.sv.
`timescale 1ns / 100ps

module testbench;
    import hck_pkg::*;

    localparam int N_RANDOM  = 1450;
    localparam int CYCLE_CAP = 100000;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [39:0] i_s_tdata  = '0;
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;
    logic [0:0]  o_m_tuser;

    int fail_cnt;
    int pending;
    int send_idle_pct = 10;
    int recv_idle_pct = 81;
    int cycles        = 0;

    always #1 i_clk = ~i_clk;

    hill_cipher_key_recovery_2x2_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    hck_key_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .i_m_tuser  (o_m_tuser),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    always @(posedge i_clk) begin
        i_m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("hill_cipher_key_recovery_2x2_core regression: fail");
            $finish;
        end
    end

    // P and C row-major, P in the low 20 bits
    function automatic logic [39:0] pack_pair(input int p00, input int p01, input int p10,
                                              input int p11, input int c00, input int c01,
                                              input int c10, input int c11);
        return {IN_W'(c11), IN_W'(c10), IN_W'(c01), IN_W'(c00),
                IN_W'(p11), IN_W'(p10), IN_W'(p01), IN_W'(p00)};
    endfunction

    function automatic logic [IN_W-1:0] rand_entry();
        if ($urandom_range(99) < 85)
            return IN_W'($urandom_range(25));
        return IN_W'($urandom_range(31));
    endfunction

    task automatic send_request(input logic [39:0] d);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic drain_requests();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random(input int n);
        logic [39:0] d;
        for (int i = 0; i < n; i++) begin
            for (int f = 0; f < 8; f++)
                d[f*IN_W +: IN_W] = rand_entry();
            send_request(d);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero and full-scale entries, out-of-range letters,
        // negative and non-invertible determinants
        send_request(pack_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_request(pack_pair(25, 25, 25, 25, 25, 25, 25, 25));
        send_request(pack_pair(31, 31, 31, 31, 31, 31, 31, 31));
        send_request(pack_pair(1, 0, 0, 1, 7, 8, 11, 11));
        send_request(pack_pair(1, 0, 0, 1, 25, 0, 31, 26));
        send_request(pack_pair(0, 1, 1, 0, 3, 5, 17, 25));
        send_request(pack_pair(0, 25, 25, 0, 25, 24, 1, 2));
        send_request(pack_pair(2, 0, 0, 1, 9, 4, 12, 20));
        send_request(pack_pair(13, 0, 0, 1, 9, 4, 12, 20));
        send_request(pack_pair(4, 2, 2, 1, 1, 2, 3, 4));
        send_request(pack_pair(27, 26, 30, 29, 31, 30, 28, 27));
        send_request(pack_pair(7, 8, 11, 11, 19, 4, 0, 14));
        send_request(pack_pair(5, 17, 8, 3, 15, 16, 14, 2));
        send_request(pack_pair(3, 0, 0, 9, 31, 0, 31, 0));
        send_request(pack_pair(25, 1, 1, 25, 0, 31, 0, 31));
        send_request(pack_pair(16, 5, 21, 10, 1, 1, 1, 1));
        drain_requests();

        send_random(N_RANDOM / 3);
        drain_requests();

        send_idle_pct = 81;
        recv_idle_pct = 10;
        send_random(N_RANDOM / 3);
        drain_requests();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(N_RANDOM - 2 * (N_RANDOM / 3));
        drain_requests();

        repeat (30) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("hill_cipher_key_recovery_2x2_core regression: pass");
        else
            $display("hill_cipher_key_recovery_2x2_core regression: fail");
        $finish;
    end

endmodule
